// ===== hdl/windowed_edge_frequency_meter_assert.svh =====
// ---------------------------------------------------------------------------
// windowed edge frequency meter assertion macros
// clocked property helpers shared by the checkers
// ---------------------------------------------------------------------------
`ifndef WINDOWED_EDGE_FREQUENCY_METER_ASSERT_SVH
`define WINDOWED_EDGE_FREQUENCY_METER_ASSERT_SVH

// property checked on every rising edge outside reset
`define WEFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define WEFM_ASSERT_IMP(lbl, ante, cons, msg) \
  `WEFM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/wefm_pkg.sv =====
// ---------------------------------------------------------------------------
// wefm_pkg
// shared types and constants of the windowed edge frequency meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package wefm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_LEN      = 3'd0,
    REG_EDGE_WINDOW     = 3'd1,
    REG_THRESHOLD_COUNT = 3'd2,
    REG_BASE_RATE       = 3'd3,
    REG_MIN_VALID       = 3'd4,
    REG_MAX_VALID       = 3'd5,
    REG_PULSES_PER_REV  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_FILL,
    S_POS,
    S_RD,
    S_ACC,
    S_EVAL,
    S_PAIR,
    S_NUM,
    S_DIVF,
    S_WF,
    S_DIVR,
    S_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [23:0] FREQ_SAT = 24'hFF_FFFF;
  localparam logic [29:0] RPM_SAT  = 30'h3FFF_FFFF;

endpackage

// ===== hdl/wefm_ram.sv =====
// ---------------------------------------------------------------------------
// wefm_ram
// simple dual port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module wefm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/wefm_div.sv =====
// ---------------------------------------------------------------------------
// wefm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module wefm_div
  import wefm_pkg::*;
#(
  parameter int unsigned W_N = 36,
  parameter int unsigned W_D = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W_N-1:0] dividend,
  input  logic [W_D-1:0] divisor,
  output logic [W_N-1:0] quotient,
  output div_stat_t      stat
);

  localparam int unsigned CW = $clog2(W_N + 1);

  logic [W_D-1:0] rem_r, rem_nxt;
  logic [W_N-1:0] quo_r, quo_nxt;
  logic [W_D-1:0] div_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [W_D:0]   sh;
  logic           ge;

  always_comb begin
    sh       = {rem_r, quo_r[W_N-1]};
    ge       = (sh >= {1'b0, div_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? W_D'(sh - {1'b0, div_r}) : sh[W_D-1:0];
      quo_nxt = {quo_r[W_N-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W_N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== hdl/windowed_edge_frequency_meter.sv =====
// result: after the scan S_NUM leads to S_OUT, through the two divides when a pair was kept
// scan: each position reads 2*edge_window bits via S_RD and S_ACC, then S_EVAL, S_PAIR after a pair
// input is stalled while a window is scanned, divided and output; one sample per cycle otherwise
// the scan is set by the single read port of the sample ram, one bit per read
// reset: synchronous active low, config and control registers back to defaults, sample ram not cleared
// ---------------------------------------------------------------------------
// windowed_edge_frequency_meter
// double banked sample window with qualified edge scan and mean frequency
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module windowed_edge_frequency_meter
  import wefm_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = 256,
  parameter int unsigned MAX_EDGES   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_sample_bit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_valid_res,
  output logic [$clog2(MAX_EDGES+1)-1:0]   out_edge_count,
  output logic [$clog2(MAX_EDGES)-1:0]     out_valid_pairs,
  output logic [23:0]                      out_freq_q8,
  output logic [29:0]                      out_rpm_q8,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int unsigned AW  = $clog2(BUFFER_SIZE);
  localparam int unsigned IW  = AW + 1;
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW  = $clog2(MAX_EDGES);
  localparam int unsigned TW  = $clog2(BUFFER_SIZE + 1);
  localparam int unsigned NW  = 16 + PW;
  localparam int unsigned DNW = 30 + PW;
  localparam int unsigned DDW = TW + 8;

  // configuration
  logic [8:0]  buf_len_r;
  logic [4:0]  edge_win_r;
  logic [4:0]  thresh_r;
  logic [15:0] base_rate_r;
  logic [23:0] min_hz_r;
  logic [23:0] max_hz_r;
  logic [7:0]  ppr_r;

  logic [IW-1:0] len_eff;
  logic [4:0]    ew_eff;
  logic [7:0]    ppr_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r   <= 9'd256;
      edge_win_r  <= 5'd3;
      thresh_r    <= 5'd2;
      base_rate_r <= 16'd10000;
      min_hz_r    <= 24'd256;
      max_hz_r    <= 24'd1280000;
      ppr_r       <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUFFER_LEN:      buf_len_r   <= cfg_data[8:0];
        REG_EDGE_WINDOW:     edge_win_r  <= cfg_data[4:0];
        REG_THRESHOLD_COUNT: thresh_r    <= cfg_data[4:0];
        REG_BASE_RATE:       base_rate_r <= cfg_data[15:0];
        REG_MIN_VALID:       min_hz_r    <= cfg_data;
        REG_MAX_VALID:       max_hz_r    <= cfg_data;
        REG_PULSES_PER_REV:  ppr_r       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    if (buf_len_r == 9'd0) begin
      len_eff = IW'(1);
    end else if (32'(buf_len_r) > BUFFER_SIZE) begin
      len_eff = IW'(BUFFER_SIZE);
    end else begin
      len_eff = IW'(buf_len_r);
    end
    ew_eff  = (edge_win_r == 5'd0) ? 5'd1 : edge_win_r;
    ppr_eff = (ppr_r == 8'd0) ? 8'd1 : ppr_r;
  end

  // state
  state_t         state_r, state_nxt;
  logic           bank_r;
  logic           scan_bank_r;
  logic [AW-1:0]  wp_r;
  logic [IW-1:0]  pos_r;
  logic [5:0]     j_r;
  logic [4:0]     lows_r, highs_r;
  logic           prev_r, cur_r;
  logic [AW-1:0]  last_r;
  logic [EW-1:0]  edges_r;
  logic [PW-1:0]  pairs_r;
  logic [TW-1:0]  tot_r;
  logic [AW-1:0]  per_r;
  logic [23+AW:0] pmin_r, pmax_r;
  logic [NW-1:0]  num_r;
  logic [DDW-1:0] den_r;
  logic           ok_r;
  logic [23:0]    fq_r;
  logic [29:0]    rpm_r;
  logic           out_valid_r;

  logic           in_acc;
  logic [IW:0]    wp_inc;
  logic [IW:0]    reach;
  logic [5:0]     last_j;
  logic [IW-1:0]  k;
  logic           bit_rd;
  logic           is_edge;
  logic           pair_ok;
  logic           ok_w;
  logic [23:0]    rate256;
  logic           out_free;

  // ram and divider controls
  logic           ram_we;
  logic [AW:0]    ram_waddr, ram_raddr;
  logic           ram_rdata_w;
  logic           div_start;
  logic [DNW-1:0] div_dividend;
  logic [DDW-1:0] div_divisor;
  logic [DNW-1:0] div_quo;
  div_stat_t      div_stat;

  assign in_acc   = in_valid && in_ready;
  assign wp_inc   = (IW+1)'(wp_r) + 1'b1;
  assign reach    = (IW+1)'(pos_r) + (IW+1)'(ew_eff);
  assign last_j   = {ew_eff, 1'b0} - 6'd1;
  assign k        = IW'(pos_r - IW'(ew_eff) + IW'(j_r));
  assign is_edge  = cur_r && !prev_r && (lows_r >= thresh_r) && (highs_r >= thresh_r);
  assign rate256  = {base_rate_r, 8'd0};
  assign pair_ok  = ((24+AW)'(rate256) >= pmin_r) && ((24+AW)'(rate256) <= pmax_r);
  assign ok_w     = (32'(edges_r) >= 2) && (pairs_r != '0) && (tot_r != '0);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL: if (in_acc && (wp_inc >= (IW+1)'(len_eff))) state_nxt = S_POS;
      S_POS: begin
        if ((reach < (IW+1)'(len_eff)) && (32'(edges_r) < MAX_EDGES)) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_NUM;
        end
      end
      S_RD:   state_nxt = S_ACC;
      S_ACC:  state_nxt = (j_r == last_j) ? S_EVAL : S_RD;
      S_EVAL: state_nxt = (is_edge && (edges_r != '0)) ? S_PAIR : S_POS;
      S_PAIR: state_nxt = S_POS;
      S_NUM:  state_nxt = ok_w ? S_DIVF : S_OUT;
      S_DIVF: state_nxt = S_WF;
      S_WF:   if (div_stat.done) state_nxt = S_DIVR;
      S_DIVR: state_nxt = S_WR;
      S_WR:   if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_FILL;
      default: state_nxt = S_FILL;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready     = (state_r == S_FILL);
    ram_we       = in_acc;
    ram_waddr    = {bank_r, wp_r};
    ram_raddr    = {scan_bank_r, k[AW-1:0]};
    div_start    = (state_r == S_DIVF) || (state_r == S_DIVR);
    div_dividend = (state_r == S_DIVF) ? DNW'({num_r, 8'd0})
                                       : DNW'({num_r, 14'd0} - {num_r, 10'd0});
    div_divisor  = (state_r == S_DIVF) ? DDW'(tot_r) : den_r;
  end

  assign bit_rd = ram_rdata_w;

  wefm_ram #(
    .WIDTH(1),
    .DEPTH(2 * BUFFER_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sample_bit),
    .raddr (ram_raddr),
    .rdata (ram_rdata_w)
  );

  wefm_div #(
    .W_N(DNW),
    .W_D(DDW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      bank_r      <= 1'b0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (wp_inc >= (IW+1)'(len_eff)) begin
          wp_r   <= '0;
          bank_r <= !bank_r;
        end else begin
          wp_r <= wp_inc[AW-1:0];
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_FILL: begin
        scan_bank_r <= bank_r;
        pos_r       <= IW'(ew_eff);
        edges_r     <= '0;
        pairs_r     <= '0;
        tot_r       <= '0;
        last_r      <= '0;
      end
      S_POS: begin
        j_r     <= '0;
        lows_r  <= '0;
        highs_r <= '0;
      end
      S_ACC: begin
        if (j_r < 6'(ew_eff)) begin
          if (!bit_rd) lows_r <= lows_r + 5'd1;
          if (j_r == 6'(ew_eff) - 6'd1) prev_r <= bit_rd;
        end else begin
          if (bit_rd) highs_r <= highs_r + 5'd1;
          if (j_r == 6'(ew_eff)) cur_r <= bit_rd;
        end
        j_r <= j_r + 6'd1;
      end
      S_EVAL: begin
        per_r  <= AW'(pos_r - IW'(last_r));
        pmin_r <= min_hz_r * AW'(pos_r - IW'(last_r));
        pmax_r <= max_hz_r * AW'(pos_r - IW'(last_r));
        if (!is_edge) begin
          pos_r <= pos_r + 1'b1;
        end else if (edges_r == '0) begin
          last_r  <= pos_r[AW-1:0];
          edges_r <= edges_r + 1'b1;
          pos_r   <= pos_r + IW'(ew_eff);
        end
      end
      S_PAIR: begin
        if (pair_ok) begin
          tot_r   <= tot_r + TW'(per_r);
          pairs_r <= pairs_r + 1'b1;
        end
        last_r  <= pos_r[AW-1:0];
        edges_r <= edges_r + 1'b1;
        pos_r   <= pos_r + IW'(ew_eff);
      end
      S_NUM: begin
        num_r <= base_rate_r * pairs_r;
        den_r <= tot_r * ppr_eff;
        ok_r  <= ok_w;
        fq_r  <= '0;
        rpm_r <= '0;
      end
      S_WF: begin
        if (div_stat.done) begin
          fq_r <= (div_quo > DNW'(FREQ_SAT)) ? FREQ_SAT : div_quo[23:0];
        end
      end
      S_WR: begin
        if (div_stat.done) begin
          rpm_r <= (div_quo > DNW'(RPM_SAT)) ? RPM_SAT : div_quo[29:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_res   <= ok_r;
          out_edge_count  <= edges_r;
          out_valid_pairs <= pairs_r;
          out_freq_q8     <= fq_r;
          out_rpm_q8      <= rpm_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/wefm_checker.sv =====
// ---------------------------------------------------------------------------
// wefm_checker
// port level checks of the windowed edge frequency meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_edge_frequency_meter_assert.svh"
module wefm_checker #(
  parameter int unsigned MAX_EDGES = 64
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_valid_res,
  input logic [$clog2(MAX_EDGES+1)-1:0] out_edge_count,
  input logic [$clog2(MAX_EDGES)-1:0]   out_valid_pairs,
  input logic [23:0]                    out_freq_q8,
  input logic [29:0]                    out_rpm_q8
);

  `WEFM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `WEFM_ASSERT_IMP(a_zero_when_invalid, out_valid && !out_valid_res,
    out_freq_q8 == 24'd0 && out_rpm_q8 == 30'd0, "nonzero rate without valid pair")
  `WEFM_ASSERT_IMP(a_nonzero_when_valid, out_valid && out_valid_res,
    out_freq_q8 != 24'd0, "zero frequency with valid pair")
  `WEFM_ASSERT_IMP(a_pairs_below_edges, out_valid,
    out_valid_pairs == '0 || 32'(out_valid_pairs) < 32'(out_edge_count), "more pairs than edges")

endmodule

bind windowed_edge_frequency_meter wefm_checker #(
  .MAX_EDGES(MAX_EDGES)
) u_wefm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_valid_res   (out_valid_res),
  .out_edge_count  (out_edge_count),
  .out_valid_pairs (out_valid_pairs),
  .out_freq_q8     (out_freq_q8),
  .out_rpm_q8      (out_rpm_q8)
);
